>>> hw/rtl/utf8_char_splitter_top_assert.svh
// assertion macros shared by the splitter modules
// both macros sample on clk_i and stay quiet while rst_ni is low
`ifndef UTF8_CHAR_SPLITTER_TOP_ASSERT_SVH
`define UTF8_CHAR_SPLITTER_TOP_ASSERT_SVH

// same-cycle implication
`define UCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/utf8cs_pkg.sv
`timescale 1ns / 1ps
package utf8cs_pkg;

  // byte order mark and register reset values
  localparam logic [7:0] MarkB0     = 8'hEF;
  localparam logic [7:0] MarkB1     = 8'hBB;
  localparam logic [7:0] MarkB2     = 8'hBF;
  localparam logic [7:0] DelimReset = 8'h2A;
  localparam logic       SkipReset  = 1'b1;

  // result beats per input item
  localparam int MaxOut = 4;
  localparam int CntW   = $clog2(MaxOut + 1);
  localparam int IdxW   = $clog2(MaxOut);

  // configuration port
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] RegDelimiter = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegSkipMark  = CfgIdxW'(1);

  // list of result bytes caused by one item
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [CntW-1:0]        cnt;
  } res_t;

  // result list plus continuation bytes still expected
  typedef struct packed {
    res_t       res;
    logic [2:0] rem;
  } seg_t;

  // continuation bytes that follow a lead byte (zero for a one-byte character)
  function automatic logic [2:0] lead_rem(input logic [7:0] b);
    logic [2:0] r;
    casez (b)
      8'b110?????: r = 3'd1;
      8'b1110????: r = 3'd2;
      8'b11110???: r = 3'd3;
      8'b111110??: r = 3'd4;
      8'b1111110?: r = 3'd5;
      8'b11111110: r = 3'd6;
      8'b11111111: r = 3'd7;
      default:     r = 3'd0;
    endcase
    return r;
  endfunction

  // append one byte, dropping anything past the last slot
  function automatic res_t push(input res_t r, input logic [7:0] b);
    res_t o;
    o = r;
    if (r.cnt < CntW'(MaxOut)) begin
      o.bytes[r.cnt[IdxW-1:0]] = b;
      o.cnt = r.cnt + CntW'(1);
    end
    return o;
  endfunction

  // pass one data byte, closing the character with the delimiter when done
  function automatic seg_t proc_byte(input seg_t s, input logic [7:0] b,
                                     input logic [7:0] delim);
    seg_t       o;
    logic [2:0] r;
    o = s;
    o.res = push(o.res, b);
    if (s.rem == 3'd0) begin
      r = lead_rem(b);
      if (r == 3'd0) begin
        o.res = push(o.res, delim);
      end else begin
        o.rem = r;
      end
    end else begin
      o.rem = s.rem - 3'd1;
      if (o.rem == 3'd0) begin
        o.res = push(o.res, delim);
      end
    end
    return o;
  endfunction

endpackage

>>> hw/rtl/utf8_char_splitter_top.sv
`timescale 1ns / 1ps
// UTF-8 character splitter: every data byte is passed through and the delimiter byte
// is inserted after each complete character (length from the lead byte's leading
// ones), a leading EF BB BF mark is dropped when enabled, and an end-of-stream item
// flushes held mark bytes and closes a partial character. Each item yields zero to
// four output beats, computed combinationally and loaded into a four-entry result
// register and drained one beat per cycle while out_ready_i is high. An item is
// accepted in the cycle the previous item's last beat is taken (or at once when the
// result register is empty), so a new item waits until every beat of the last one is
// out, and an item with no beats, such as a held mark byte, does not hold the block.
// Configuration writes take effect on the next item.
module utf8_char_splitter_top
  import utf8cs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_stream_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                last_of_run_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [7:0] delim_q;
  logic       skip_q;
  logic       in_acc;
  res_t       res;

  assign in_acc = in_valid_i && in_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DelimReset;
      skip_q  <= SkipReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegDelimiter: delim_q <= cfg_data_i[7:0];
        RegSkipMark:  skip_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // mark check and character segmentation
  utf8cs_seg u_seg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (in_acc),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .delim_i         (delim_q),
    .skip_i          (skip_q),
    .res_o           (res)
  );

  // result register and beat serializer
  utf8cs_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_of_run_o)
  );

endmodule

>>> hw/rtl/utf8cs_seg.sv
`timescale 1ns / 1ps
`include "utf8_char_splitter_top_assert.svh"
module utf8cs_seg
  import utf8cs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_stream_i,
  input  logic [7:0] delim_i,
  input  logic       skip_i,
  output res_t       res_o
);

  typedef enum logic [1:0] {
    PhWait = 2'd0,
    PhEf   = 2'd1,
    PhEfBb = 2'd2,
    PhDone = 2'd3
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [2:0] rem_q, rem_d;
  logic [7:0] expect_byte;
  logic       mark_hit;
  seg_t       s0, s1, s2, s3;

  // next mark byte awaited in the current phase
  always_comb begin
    unique case (phase_q)
      PhWait:  expect_byte = MarkB0;
      PhEf:    expect_byte = MarkB1;
      PhEfBb:  expect_byte = MarkB2;
      default: expect_byte = MarkB0;
    endcase
  end

  assign mark_hit = skip_i && !end_of_stream_i && (phase_q != PhDone)
                    && (data_byte_i == expect_byte);

  // replay held mark bytes unless the byte extends the mark, then pass the current byte or, on end of stream, close
  always_comb begin
    s0     = '0;
    s0.rem = rem_q;
    s1     = s0;
    if (!mark_hit && (phase_q == PhEf || phase_q == PhEfBb)) begin
      s1 = proc_byte(s0, MarkB0, delim_i);
    end
    s2 = s1;
    if (!mark_hit && phase_q == PhEfBb) begin
      s2 = proc_byte(s1, MarkB1, delim_i);
    end
    s3 = s2;
    if (end_of_stream_i) begin
      if (s2.rem != 3'd0) begin
        s3.res = push(s2.res, delim_i);
      end
      s3.rem = 3'd0;
    end else if (!mark_hit) begin
      s3 = proc_byte(s2, data_byte_i, delim_i);
    end
  end

  assign res_o = s3.res;

  // next mark phase and remaining continuation count
  always_comb begin
    rem_d = s3.rem;
    if (end_of_stream_i) begin
      phase_d = PhWait;
    end else if (mark_hit) begin
      phase_d = phase_e'(phase_q + 2'd1);
    end else begin
      phase_d = PhDone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhWait;
      rem_q   <= 3'd0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
    end
  end

  `UCS_ASSERT_IMP(a_no_char_during_mark, phase_q != PhDone, rem_q == 3'd0,
                  "character pending while mark check is open")
  `UCS_ASSERT_NXT(a_eos_clears, adv_i && end_of_stream_i,
                  phase_q == PhWait && rem_q == 3'd0,
                  "end of stream did not clear state")

endmodule

>>> hw/rtl/utf8cs_outbuf.sv
`timescale 1ns / 1ps
`include "utf8_char_splitter_top_assert.svh"
module utf8cs_outbuf
  import utf8cs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  res_t       res_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  logic [MaxOut-1:0][7:0] bytes_q;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic                   out_fire, is_last, load, idx_ok;

  assign out_valid_o = (cnt_q != '0);
  assign is_last     = ((CntW'(idx_q) + CntW'(1)) == cnt_q);
  assign out_fire    = out_valid_o && out_ready_i;
  assign in_ready_o  = !out_valid_o || (out_fire && is_last);
  assign load        = in_valid_i && in_ready_o;
  assign out_byte_o  = bytes_q[idx_q];
  assign last_o      = is_last;
  assign idx_ok      = (CntW'(idx_q) < cnt_q);

  // load a new result list, step to the next beat, or empty the register after the last one
  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load) begin
      cnt_d = res_i.cnt;
      idx_d = '0;
    end else if (out_fire) begin
      if (is_last) begin
        cnt_d = '0;
        idx_d = '0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  // result bytes
  always_ff @(posedge clk_i) begin
    if (load) begin
      bytes_q <= res_i.bytes;
    end
  end

  `UCS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CntW'(MaxOut), "result count out of range")
  `UCS_ASSERT_IMP(a_idx_bound, out_valid_o, idx_ok, "beat index past result count")

endmodule

>>> tb/tb_utf8_char_splitter_top.sv
`timescale 1ns / 1ps
import utf8cs_pkg::*;

// where the byte order mark check stands
typedef enum logic [1:0] {
  AwaitMark,
  HeldEf,
  HeldEfBb,
  MarkDone
} mark_phase_e;

// predicts the output beats of the splitter and checks them in order
class char_split_sb;
  typedef struct packed {
    logic [7:0] val;
    logic       last;
  } beat_t;

  beat_t       expected_q[$];
  beat_t       run_q[$];
  logic [7:0]  delim;
  logic        skip_en;
  mark_phase_e phase;
  logic [2:0]  conts_left;
  int unsigned errors;

  function new();
    delim      = DelimReset;
    skip_en    = SkipReset;
    phase      = AwaitMark;
    conts_left = 3'd0;
    errors     = 0;
  endfunction

  function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    if (idx == RegDelimiter) begin
      delim = d;
    end else if (idx == RegSkipMark) begin
      skip_en = d[0];
    end
  endfunction

  // one item never yields more than four beats
  function void add_beat(input logic [7:0] v);
    if (run_q.size() < MaxOut) begin
      run_q.push_back('{val: v, last: 1'b0});
    end
  endfunction

  // number of leading one bits of a lead byte
  function int unsigned ones_run(input logic [7:0] v);
    int unsigned n;
    n = 0;
    while (n < 8 && v[7-n]) begin
      n++;
    end
    return n;
  endfunction

  // pass a data byte, closing the character when it is complete
  function void pass_data(input logic [7:0] v);
    int unsigned n;
    add_beat(v);
    if (conts_left == 3'd0) begin
      n = ones_run(v);
      if (n < 2) begin
        add_beat(delim);
      end else begin
        conts_left = 3'(n - 1);
      end
    end else begin
      conts_left = conts_left - 3'd1;
      if (conts_left == 3'd0) begin
        add_beat(delim);
      end
    end
  endfunction

  // held mark bytes come out as plain data
  function void replay_mark();
    if (phase == HeldEf || phase == HeldEfBb) begin
      pass_data(MarkB0);
    end
    if (phase == HeldEfBb) begin
      pass_data(MarkB1);
    end
  endfunction

  function void note_input(input logic [7:0] v, input logic eos);
    run_q.delete();
    if (eos) begin
      replay_mark();
      if (conts_left != 3'd0) begin
        add_beat(delim);
      end
      phase      = AwaitMark;
      conts_left = 3'd0;
    end else if (phase == MarkDone) begin
      pass_data(v);
    end else if (!skip_en) begin
      replay_mark();
      phase = MarkDone;
      pass_data(v);
    end else begin
      case (phase)
        AwaitMark: begin
          if (v == MarkB0) begin
            phase = HeldEf;
          end else begin
            phase = MarkDone;
            pass_data(v);
          end
        end
        HeldEf: begin
          if (v == MarkB1) begin
            phase = HeldEfBb;
          end else begin
            replay_mark();
            phase = MarkDone;
            pass_data(v);
          end
        end
        default: begin
          if (v == MarkB2) begin
            phase = MarkDone;
          end else begin
            replay_mark();
            phase = MarkDone;
            pass_data(v);
          end
        end
      endcase
    end
    if (run_q.size() > 0) begin
      run_q[run_q.size()-1].last = 1'b1;
    end
    foreach (run_q[i]) begin
      expected_q.push_back(run_q[i]);
    end
  endfunction

  function void check_result(input logic [7:0] v, input logic last);
    beat_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected beat, expected none, got byte %02h last %0b", $time, v, last);
      errors++;
    end else begin
      want = expected_q.pop_front();
      if (v !== want.val) begin
        $display("%0t: out_byte expected %02h, got %02h", $time, want.val, v);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last_of_run expected %0b, got %0b", $time, want.last, last);
        errors++;
      end
    end
  endfunction
endclass

module tb_utf8_char_splitter_top;

  localparam logic [8:0] EosItem = 9'h100;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [7:0]          data_byte_i;
  logic                end_of_stream_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [7:0]          out_byte_o;
  logic                last_of_run_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  char_split_sb sb = new();
  int unsigned  idle_pct = 23;
  int unsigned  item_cnt = 0;

  // directed items: bit 8 set marks an end of stream
  logic [8:0] directed_items [25] = '{
    9'h0EF, 9'h0BB, 9'h0BF, 9'h041, 9'h000, 9'h080, EosItem,
    9'h0EF, 9'h041, EosItem,
    9'h0EF, 9'h0BB, 9'h000, EosItem,
    9'h0EF, 9'h0BB, EosItem,
    9'h0FF, 9'h080, 9'h0BF, EosItem,
    9'h0C3, 9'h0A9, EosItem, 9'h0EF
  };

  utf8_char_splitter_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_stream_i(end_of_stream_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // receiver stalls at random
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= idle_pct);
  end

  // input beats feed the predictor before output beats are checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_input(data_byte_i, end_of_stream_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_result(out_byte_o, last_of_run_o);
      end
    end
  end

  // one input beat, entered and left at a falling edge
  task automatic send(input logic [7:0] v, input logic eos);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= eos ? 8'($urandom) : v;
    end_of_stream_i <= eos;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    item_cnt++;
  endtask

  // write strobe for one cycle, then the strobe is held low before the task returns
  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    sb.write_reg(idx, d);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // drop valid and let every expected beat come out
  task automatic wait_idle();
    int unsigned guard;
    in_valid_i <= 1'b0;
    guard = 0;
    while (sb.expected_q.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // one character of 1 to 8 bytes, sometimes cut short by an end of stream
  task automatic send_char();
    int unsigned len;
    int unsigned conts;
    logic [7:0]  lead;
    bit          cut;
    len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 8);
    if (len == 1) begin
      lead = 8'($urandom_range(0, 127));
    end else begin
      lead = (8'hFF << (8 - len)) | (8'($urandom) & (8'hFF >> (len + 1)));
    end
    conts = len - 1;
    cut   = (len > 1) && ($urandom_range(0, 9) == 0);
    if (cut) begin
      conts = $urandom_range(0, len - 2);
    end
    send(lead, 1'b0);
    repeat (conts) send(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
    if (cut) begin
      send(8'h00, 1'b1);
    end
  endtask

  // mostly well-formed streams, with noise in between
  task automatic random_items(input int unsigned n);
    int unsigned stop;
    stop = item_cnt + n;
    while (item_cnt < stop) begin
      if ($urandom_range(0, 99) < 80) begin
        case ($urandom_range(0, 5))
          0, 1: begin
            send(MarkB0, 1'b0);
            send(MarkB1, 1'b0);
            send(MarkB2, 1'b0);
          end
          2: send(MarkB0, 1'b0);
          3: begin
            send(MarkB0, 1'b0);
            send(MarkB1, 1'b0);
          end
          default: ;
        endcase
        repeat ($urandom_range(1, 6)) send_char();
        if ($urandom_range(0, 2) == 0) begin
          send(8'h00, 1'b1);
        end
      end else begin
        send(8'($urandom), $urandom_range(0, 9) == 0);
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    data_byte_i     = 8'h00;
    end_of_stream_i = 1'b0;
    out_ready_i     = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings, directed items; the stream ends with a held EF
    foreach (directed_items[i]) begin
      send(directed_items[i][7:0], directed_items[i][8]);
    end
    wait_idle();

    // mark check off while EF is held, zero delimiter
    write_cfg(RegSkipMark, CfgDataW'(0));
    write_cfg(RegDelimiter, 8'h00);
    random_items(35);
    wait_idle();

    // mark check on, all-ones delimiter, no stalls on either side
    idle_pct = 0;
    write_cfg(RegSkipMark, CfgDataW'(1));
    write_cfg(RegDelimiter, 8'hFF);
    send(8'h00, 1'b1);
    random_items(35);
    wait_idle();

    // random settings and a write to an unused index
    idle_pct = 23;
    write_cfg(RegDelimiter, 8'($urandom));
    write_cfg(RegSkipMark, CfgDataW'($urandom_range(0, 1)));
    write_cfg(CfgIdxW'($urandom_range(2, (1 << CfgIdxW) - 1)), 8'($urandom));
    random_items(45);
    wait_idle();

    while (sb.expected_q.size() != 0) begin
      $display("%0t: missing beat, expected byte %02h last %0b, got none", $time,
               sb.expected_q[0].val, sb.expected_q[0].last);
      void'(sb.expected_q.pop_front());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard
  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/utf8cs_pkg.sv
hw/rtl/utf8cs_seg.sv
hw/rtl/utf8cs_outbuf.sv
hw/rtl/utf8_char_splitter_top.sv
tb/tb_utf8_char_splitter_top.sv
